FILE: rtl/core/rle_sprite_pixel_decoder_unit_assert.svh
// assertion macros shared by the sprite decoder rtl
// each macro expects clk and rst_n in scope; empty when SYNTHESIS is set
`ifndef RLE_SPRITE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define RLE_SPRITE_PIXEL_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RSPD_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rspd assertion failed");
`define RSPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rspd assertion failed");
`define RSPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rspd assertion failed");
`else
`define RSPD_ASSERT(lbl, expr)
`define RSPD_ASSERT_IMP(lbl, ante, cons)
`define RSPD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/rspd_pkg.sv
// types and constants of the run-length sprite decoder
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rspd_pkg;

  localparam int DEFAULT_COORD_WIDTH = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int ARG_WIDTH       = 13;

  localparam logic [11:0] FRAME_WIDTH_RESET = 12'd1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_FRAME_WIDTH = 3'd2,
    REG_VIEW_LEFT   = 3'd3,
    REG_VIEW_RIGHT  = 3'd4,
    REG_VIEW_TOP    = 3'd5,
    REG_VIEW_BOTTOM = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_RUN_OPEN = 2'd0,
    OP_PIXEL    = 2'd1,
    OP_ROW_SKIP = 2'd2,
    OP_COL_SKIP = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 start;
    logic [ARG_WIDTH-1:0] arg;
  } q_entry_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [11:0]        frame_width;
    logic [14:0]        view_left;
    logic [14:0]        view_right;
    logic [14:0]        view_top;
    logic [14:0]        view_bottom;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/rle_sprite_pixel_decoder_unit.sv
// top level of the run-length sprite pixel decoder: config registers,
// front end, beat queue and back end; depends on rspd_pkg and the rspd_* modules
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tdata code_word[15:0], tuser frame_start[0]
// out_     out  out_tvalid/out_tready  tdata x[15:0] y[31:16] pal[39:32] alpha[43:40]
// cfg_     in   cfg_valid/cfg_ready    cfg_index register, cfg_data value
//
// one code word per cycle while the queue is not full; the front end classifies a
// beat in the cycle it is accepted and the queue registers it; the back end pops
// it and loads a visible pixel into the output register that drives out_tvalid
// the back end takes a beat whenever the output register is free or drained
// in_tready drops only when the queue is full; cfg_ready is always high
// synchronous active-low reset clears cursor, run count, queue and registers
`timescale 1ns / 1ps
`default_nettype none

module rle_sprite_pixel_decoder_unit #(
  parameter int COORD_WIDTH = rspd_pkg::DEFAULT_COORD_WIDTH,
  parameter int QUEUE_DEPTH = rspd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [15:0]                          in_tdata,   // code_word
  input  wire  [0:0]                           in_tuser,   // frame_start
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [47:0]                          out_tdata,  // pixel_x, pixel_y, palette, alpha
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [rspd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire  [rspd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import rspd_pkg::*;

  cfg_t     cfg_r;
  logic     q_full;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  logic     head_valid;
  q_entry_t head;

  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [7:0]         pal;
  logic [3:0]         alpha;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= '0;
      cfg_r.origin_y    <= '0;
      cfg_r.frame_width <= FRAME_WIDTH_RESET;
      cfg_r.view_left   <= '0;
      cfg_r.view_right  <= '0;
      cfg_r.view_top    <= '0;
      cfg_r.view_bottom <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_ORIGIN_X:    cfg_r.origin_x    <= signed'(cfg_data);
        REG_ORIGIN_Y:    cfg_r.origin_y    <= signed'(cfg_data);
        REG_FRAME_WIDTH: cfg_r.frame_width <= cfg_data[11:0];
        REG_VIEW_LEFT:   cfg_r.view_left   <= cfg_data[14:0];
        REG_VIEW_RIGHT:  cfg_r.view_right  <= cfg_data[14:0];
        REG_VIEW_TOP:    cfg_r.view_top    <= cfg_data[14:0];
        REG_VIEW_BOTTOM: cfg_r.view_bottom <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  rspd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_code_word   (in_tdata),
    .in_frame_start (in_tuser[0]),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  rspd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rspd_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_pixel_x       (px),
    .out_pixel_y       (py),
    .out_palette_index (pal),
    .out_alpha_level   (alpha)
  );

  assign out_tdata = {4'b0000, alpha, pal, py, px};

endmodule

`default_nettype wire

FILE: rtl/core/rspd_front.sv
// front end: accepts code words, tracks the open run, classifies each beat
// depends on rspd_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "rle_sprite_pixel_decoder_unit_assert.svh"

module rspd_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [15:0]           in_code_word,
  input  wire                   in_frame_start,
  input  wire                   q_full,
  output logic                  push,
  output rspd_pkg::q_entry_t    push_entry
);
  import rspd_pkg::*;

  logic [7:0] run_r;
  logic [7:0] run_nxt;
  logic [7:0] run_eff;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    run_eff          = in_frame_start ? 8'd0 : run_r;
    push_entry.start = in_frame_start;
    push_entry.arg   = in_code_word[ARG_WIDTH-1:0];
    push_entry.op    = OP_RUN_OPEN;
    run_nxt          = run_r;
    if (run_eff != 8'd0) begin
      push_entry.op = OP_PIXEL;
      run_nxt       = run_eff - 8'd1;
    end else if (in_code_word[15:14] != 2'b00) begin
      push_entry.op = in_code_word[14] ? OP_ROW_SKIP : OP_COL_SKIP;
      run_nxt       = 8'd0;
    end else begin
      push_entry.op = OP_RUN_OPEN;
      run_nxt       = in_code_word[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 8'd0;
    end else if (push) begin
      run_r <= run_nxt;
    end
  end

  `RSPD_ASSERT_NXT(a_run_count_down, push && run_eff != 8'd0, run_r == $past(run_r) - 8'd1)

endmodule

`default_nettype wire

FILE: rtl/core/rspd_queue.sv
// short queue of classified beats between front and back
// depends on rspd_pkg; DEPTH must be a power of two
`timescale 1ns / 1ps
`default_nettype none
`include "rle_sprite_pixel_decoder_unit_assert.svh"

module rspd_queue #(
  parameter int DEPTH = rspd_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  rspd_pkg::q_entry_t push_entry,
  output logic               full,
  input  wire                pop,
  output logic               head_valid,
  output rspd_pkg::q_entry_t head
);
  import rspd_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] cnt_nxt;

  assign full       = (cnt_r == CNTW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `RSPD_ASSERT(a_cnt_range, cnt_r <= CNTW'(DEPTH))
  `RSPD_ASSERT_IMP(a_pop_nonempty, pop, cnt_r != '0)
  `RSPD_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + CNTW'(1))

endmodule

`default_nettype wire

FILE: rtl/core/rspd_back.sv
// back end: cursor update, viewport test and output register
// depends on rspd_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "rle_sprite_pixel_decoder_unit_assert.svh"

module rspd_back #(
  parameter int COORD_WIDTH = rspd_pkg::DEFAULT_COORD_WIDTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  rspd_pkg::cfg_t     cfg,
  input  wire                head_valid,
  input  rspd_pkg::q_entry_t head,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] out_pixel_x,
  output logic signed [15:0] out_pixel_y,
  output logic [7:0]         out_palette_index,
  output logic [3:0]         out_alpha_level
);
  import rspd_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int EW = ((CW > 16) ? CW : 16) + 3;
  localparam logic signed [EW-1:0] CMAX = signed'((EW'(1) << (CW - 1)) - EW'(1));
  localparam logic signed [EW-1:0] CMIN = ~CMAX;

  function automatic logic signed [CW-1:0] sat_f(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > CMAX) begin
      r = CMAX[CW-1:0];
    end else if (v < CMIN) begin
      r = CMIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [EW-1:0] ext_f(input logic signed [CW-1:0] v);
    return signed'({{(EW-CW){v[CW-1]}}, v});
  endfunction

  logic signed [CW-1:0] cx_r, cx_nxt;
  logic signed [CW-1:0] cy_r, cy_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [15:0]   px_r, py_r;
  logic [7:0]           pal_r;
  logic [3:0]           alpha_r;

  logic signed [CW-1:0] base_x, base_y;
  logic signed [EW-1:0] bx, by, ox, oy, fw, cnt, lim, vl, vr, vt, vb, xs_e;
  logic signed [CW-1:0] xs;
  logic                 visible;
  logic                 produce;

  assign ox  = signed'({{(EW-16){cfg.origin_x[15]}}, cfg.origin_x});
  assign oy  = signed'({{(EW-16){cfg.origin_y[15]}}, cfg.origin_y});
  assign fw  = signed'({{(EW-12){1'b0}}, cfg.frame_width});
  assign vl  = signed'({{(EW-15){1'b0}}, cfg.view_left});
  assign vr  = signed'({{(EW-15){1'b0}}, cfg.view_right});
  assign vt  = signed'({{(EW-15){1'b0}}, cfg.view_top});
  assign vb  = signed'({{(EW-15){1'b0}}, cfg.view_bottom});
  assign cnt = signed'({{(EW-8){1'b0}}, head.arg[7:0]});
  assign lim = ox + fw;

  assign pop = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    base_x  = head.start ? sat_f(ox) : cx_r;
    base_y  = head.start ? sat_f(oy) : cy_r;
    bx      = ext_f(base_x);
    by      = ext_f(base_y);
    visible = (bx >= vl) && (bx < vr) && (by >= vt) && (by < vb);
    xs      = sat_f(bx + cnt);
    xs_e    = ext_f(xs);
    cx_nxt  = base_x;
    cy_nxt  = base_y;
    produce = 1'b0;
    case (head.op)
      OP_PIXEL: begin
        produce = visible;
        cx_nxt  = sat_f(bx + EW'(1));
      end
      OP_ROW_SKIP: begin
        cy_nxt = sat_f(by + cnt);
      end
      OP_COL_SKIP: begin
        // one wrap to the next row past the frame's right edge
        if (xs_e >= lim) begin
          cx_nxt = sat_f(xs_e - fw);
          cy_nxt = sat_f(by + EW'(1));
        end else begin
          cx_nxt = xs;
        end
      end
      default: begin
        cx_nxt = base_x;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = produce;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r        <= '0;
      cy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      px_r    <= bx[15:0];
      py_r    <= by[15:0];
      pal_r   <= head.arg[8:1];
      alpha_r <= head.arg[12:9];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = px_r;
  assign out_pixel_y       = py_r;
  assign out_palette_index = pal_r;
  assign out_alpha_level   = alpha_r;

  `RSPD_ASSERT_IMP(a_no_pop_stalled, out_valid_r && !out_ready, !pop)
  `RSPD_ASSERT_NXT(a_result_loaded, pop && produce, out_valid_r)

endmodule

`default_nettype wire

FILE: tb/sv/rle_sprite_pixel_decoder_unit_test.sv
// self-checking testbench for rle_sprite_pixel_decoder_unit: queued code words
// driven on the in_ stream, predicted pixels checked on the out_ stream
// depends on rspd_pkg and the decoder rtl
`timescale 1ns / 1ps

module rle_sprite_pixel_decoder_unit_test;
  import rspd_pkg::*;

  typedef struct {
    logic [15:0] word;
    logic        start;
  } code_beat_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  pal;
    logic [3:0]  alpha;
  } pixel_t;

  localparam longint COORD_MAX = 32767;
  localparam longint COORD_MIN = -32768;
  localparam logic [15:0] CMD_MASK   = 16'hC000;
  localparam logic [15:0] ROW_SKIP   = 16'h4000;
  localparam logic [15:0] COL_SKIP   = 16'h8000;
  localparam logic [15:0] COUNT_MASK = 16'h00FF;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // code_word
  logic [0:0]  in_tuser = '0;   // frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // pixel_x, pixel_y, palette_index, alpha_level, pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = REG_ORIGIN_X;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  code_beat_t pending_words[$];
  pixel_t     expected_pixels[$];
  int         queued_total = 0;

  // shadow registers and cursor state
  longint org_x = 0;
  longint org_y = 0;
  longint frm_w = 1;
  longint win_l = 0;
  longint win_r = 0;
  longint win_t = 0;
  longint win_b = 0;
  longint cur_x = 0;
  longint cur_y = 0;
  int     run_left = 0;

  int fail_count = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  rle_sprite_pixel_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic void decode_word(logic [15:0] w, logic s);
    longint n;
    pixel_t px;
    n = longint'(w[7:0]);
    if (s) begin
      cur_x = clamp_coord(org_x);
      cur_y = clamp_coord(org_y);
      run_left = 0;
    end
    if (run_left != 0) begin
      if (cur_x >= win_l && cur_x < win_r && cur_y >= win_t && cur_y < win_b) begin
        px.x = cur_x[15:0];
        px.y = cur_y[15:0];
        px.pal = w[8:1];
        px.alpha = w[12:9];
        expected_pixels.insert(expected_pixels.size(), px);
      end
      cur_x = clamp_coord(cur_x + 1);
      run_left = (run_left - 1) & 8'hFF;
    end else if ((w & CMD_MASK) != 0) begin
      if ((w & ROW_SKIP) != 0) begin
        cur_y = clamp_coord(cur_y + n);
      end else begin
        cur_x = clamp_coord(cur_x + n);
        if (cur_x >= org_x + frm_w) begin
          cur_x = clamp_coord(cur_x - frm_w);
          cur_y = clamp_coord(cur_y + 1);
        end
      end
    end else begin
      run_left = int'(n);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] e, logic [15:0] a);
    if (a !== e) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s expected %h actual %h", $time, name, e, a);
    end
  endfunction

  function automatic void queue_word(logic [15:0] w, logic s);
    code_beat_t b;
    b.word = w;
    b.start = s;
    pending_words.insert(pending_words.size(), b);
    queued_total++;
  endfunction

  // one frame of well-formed commands and runs with random content, plus some noise
  function automatic int add_frame();
    int cnt;
    int pieces;
    int pick;
    int len;
    logic s;
    logic [15:0] rnd;
    cnt = 0;
    s = 1'b1;
    pieces = $urandom_range(2, 12);
    for (int i = 0; i < pieces; i++) begin
      pick = $urandom_range(0, 99);
      rnd = 16'($urandom);
      if (pick < 45) begin
        len = (pick < 2) ? 0 : (pick < 5) ? $urandom_range(13, 255) : $urandom_range(1, 12);
        queue_word((rnd & ~CMD_MASK & ~COUNT_MASK) | len[7:0], s);
        for (int k = 0; k < len; k++) begin
          rnd = 16'($urandom);
          queue_word(rnd, $urandom_range(0, 99) == 0);
        end
        cnt += len + 1;
      end else if (pick < 70) begin
        len = (pick < 50) ? $urandom_range(0, 255) : $urandom_range(0, 8);
        queue_word((rnd & ~CMD_MASK & ~COUNT_MASK) | COL_SKIP | len[7:0], s);
        cnt++;
      end else if (pick < 88) begin
        len = (pick < 72) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        queue_word((rnd & ~ROW_SKIP & ~COUNT_MASK) | ROW_SKIP | len[7:0], s);
        cnt++;
      end else begin
        queue_word(rnd, s | ($urandom_range(0, 7) == 0));
        cnt++;
      end
      s = 1'b0;
    end
    return cnt;
  endfunction

  task automatic cfg_write(cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X:    org_x = longint'($signed(val));
      REG_ORIGIN_Y:    org_y = longint'($signed(val));
      REG_FRAME_WIDTH: frm_w = longint'(val[11:0]);
      REG_VIEW_LEFT:   win_l = longint'(val[14:0]);
      REG_VIEW_RIGHT:  win_r = longint'(val[14:0]);
      REG_VIEW_TOP:    win_t = longint'(val[14:0]);
      REG_VIEW_BOTTOM: win_b = longint'(val[14:0]);
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [15:0] ox, logic [15:0] oy, logic [15:0] fw,
                              logic [15:0] vl, logic [15:0] vr,
                              logic [15:0] vt, logic [15:0] vb);
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_FRAME_WIDTH, fw & 16'h0FFF);
    cfg_write(REG_VIEW_LEFT, vl & 16'h7FFF);
    cfg_write(REG_VIEW_RIGHT, vr & 16'h7FFF);
    cfg_write(REG_VIEW_TOP, vt & 16'h7FFF);
    cfg_write(REG_VIEW_BOTTOM, vb & 16'h7FFF);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_regs(int phase);
    logic [15:0] ox, oy, fw, vl, vr, vt, vb;
    ox = 16'($urandom_range(0, 120)) - 16'd20;
    oy = 16'($urandom_range(0, 120)) - 16'd20;
    fw = 16'($urandom_range(1, 48));
    vl = 16'($urandom_range(0, 40));
    vr = vl + 16'($urandom_range(0, 200));
    vt = 16'($urandom_range(0, 40));
    vb = vt + 16'($urandom_range(0, 200));
    case (phase % 7)
      0: ox = 16'h8000;
      1: begin
        oy = 16'h7FFF;
        vt = 16'h0000;
        vb = 16'h7FFF;
      end
      2: fw = 16'h0000;
      3: fw = 16'h0FFF;
      4: begin
        vl = 16'($urandom);
        vr = 16'($urandom);
        vt = 16'($urandom);
        vb = 16'($urandom);
        ox = 16'($urandom);
        oy = 16'($urandom);
        fw = 16'($urandom);
      end
      5: vr = vl;
      default: begin
        vl = 16'h0000;
        vr = 16'h7FFF;
      end
    endcase
    program_regs(ox, oy, fw, vl, vr, vt, vb);
  endtask

  // wait until nothing is queued, offered or owed for a run of quiet cycles
  task automatic settle();
    int quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      if (pending_words.size() != 0 || in_tvalid || out_tvalid ||
          expected_pixels.size() != 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  always @(posedge clk) begin : drive
    code_beat_t nxt;
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        decode_word(in_tdata, in_tuser[0]);
        offer = 1'b0;
      end
      if (!offer && pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
        nxt = pending_words.pop_front();
        in_tdata <= nxt.word;
        in_tuser <= nxt.start;
        offer = 1'b1;
      end
      in_tvalid <= offer;
    end
  end

  always @(posedge clk) begin : watch
    pixel_t exp_px;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: pixel beat expected none actual %h", $time, out_tdata);
        end else begin
          exp_px = expected_pixels.pop_front();
          check_field("pixel_x", exp_px.x, out_tdata[15:0]);
          check_field("pixel_y", exp_px.y, out_tdata[31:16]);
          check_field("palette_index", {8'd0, exp_px.pal}, {8'd0, out_tdata[39:32]});
          check_field("alpha_level", {12'd0, exp_px.alpha}, {12'd0, out_tdata[43:40]});
        end
      end
      if (hold_req && !hold_done) begin
        hold_cnt = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] rnd;
    int phase_made;
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // runs, pixel field extremes, zero run, skips with and without wrap
    program_regs(16'd10, 16'd20, 16'd8, 16'd0, 16'd200, 16'd0, 16'd200);
    queue_word(16'h0003, 1'b1);
    queue_word(16'h0000, 1'b0);
    queue_word(16'hFFFF, 1'b0);
    queue_word(16'h0155, 1'b0);
    queue_word(16'h3F00, 1'b0);
    queue_word(ROW_SKIP | 16'h0002, 1'b0);
    queue_word(COL_SKIP | 16'h0001, 1'b0);
    queue_word(COL_SKIP | 16'h00FF, 1'b0);
    queue_word(CMD_MASK | 16'h0001, 1'b0);
    queue_word(16'h0002, 1'b0);
    queue_word(16'h1234, 1'b0);
    queue_word(ROW_SKIP | 16'h0001, 1'b1);
    queue_word(16'h0001, 1'b0);
    queue_word(16'hE001, 1'b0);
    settle();

    // cursor saturation at the top of the coordinate range
    program_regs(16'd32765, 16'd32700, 16'd4095, 16'd0, 16'd32767, 16'd0, 16'd32767);
    queue_word(16'h0003, 1'b1);
    queue_word(16'h1A5B, 1'b0);
    queue_word(16'h0C3D, 1'b0);
    queue_word(16'h1FFF, 1'b0);
    queue_word(COL_SKIP | 16'h00FF, 1'b0);
    queue_word(ROW_SKIP | 16'h00FF, 1'b0);
    queue_word(16'h0001, 1'b0);
    queue_word(16'h0ABC, 1'b0);
    settle();

    // zero frame width wrap and an empty viewport
    program_regs(16'd5, 16'd5, 16'd0, 16'd50, 16'd10, 16'd0, 16'd100);
    queue_word(COL_SKIP | 16'h0003, 1'b1);
    queue_word(16'h0001, 1'b0);
    queue_word(16'h0F0F, 1'b0);
    settle();

    // output held off while a long visible run keeps coming
    program_regs(16'd0, 16'd0, 16'd64, 16'd0, 16'd32767, 16'd0, 16'd32767);
    steady = 1'b1;
    hold_req = 1'b1;
    queue_word(16'd200, 1'b1);
    for (int i = 0; i < 200; i++) begin
      rnd = 16'($urandom);
      queue_word(rnd, 1'b0);
    end
    settle();
    steady = 1'b0;

    phase = 0;
    while (queued_total < 1000) begin
      random_regs(phase);
      steady = (phase == 3);
      phase_made = 0;
      while (phase_made < 120) phase_made += add_frame();
      settle();
      steady = 1'b0;
      phase++;
    end

    settle();
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("rle_sprite_pixel_decoder_unit_test OK");
    end else begin
      $display("rle_sprite_pixel_decoder_unit_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("rle_sprite_pixel_decoder_unit_test NOT OK");
    $finish;
  end

endmodule
